@@ design/seue_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seue_pkg
// Shared types and constants for the stereo envelope upward expander: frame
// structs, configuration bundle, sequencer states and register map.
// ----------------------------------------------------------------------------
package seue_pkg;

    // Sample format: signed, one integer bit, SAMPLE_W-1 fraction bits
    localparam int SAMPLE_W    = 24;
    localparam int ENV_EXTRA_DEF = 24;

    // Configuration field widths
    localparam int COEF_W  = 24;
    localparam int LEVEL_W = 24;
    localparam int SLOPE_W = 16;
    localparam int GAIN_W  = 15;

    // Unity gain in Q2.14
    localparam int UNITY_Q14 = 16384;

    // Frames waiting between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Register map, one 32-bit word per register
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_RELEASE = 3'd1;
    localparam logic [2:0] REG_GATE    = 3'd2;
    localparam logic [2:0] REG_FLOOR   = 3'd3;
    localparam logic [2:0] REG_SLOPE   = 3'd4;
    localparam logic [2:0] REG_LIMIT   = 3'd5;

    // Register reset values
    localparam logic [COEF_W-1:0]  RST_ATTACK  = 24'd16777;
    localparam logic [COEF_W-1:0]  RST_RELEASE = 24'd1678;
    localparam logic [LEVEL_W-1:0] RST_GATE    = 24'd8389;
    localparam logic [LEVEL_W-1:0] RST_FLOOR   = 24'd838861;
    localparam logic [SLOPE_W-1:0] RST_SLOPE   = 16'd32768;
    localparam logic [GAIN_W-1:0]  RST_LIMIT   = 15'd20480;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } t_frame_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_frame_out;

    // Classified frame: sample and its magnitude per channel
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_x;
        logic        [SAMPLE_W-1:0] left_mag;
        logic signed [SAMPLE_W-1:0] right_x;
        logic        [SAMPLE_W-1:0] right_mag;
    } t_work;

    typedef struct packed {
        logic [COEF_W-1:0]  attack_coef;
        logic [COEF_W-1:0]  release_coef;
        logic [LEVEL_W-1:0] gate_level;
        logic [LEVEL_W-1:0] envelope_floor;
        logic [SLOPE_W-1:0] gain_slope;
        logic [GAIN_W-1:0]  gain_limit;
    } t_cfg;

    // Back-end sequencer states
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_MHI   = 11'b000_0000_0010,
        S_MLO   = 11'b000_0000_0100,
        S_ADD   = 11'b000_0000_1000,
        S_ENV   = 11'b000_0001_0000,
        S_GATE  = 11'b000_0010_0000,
        S_DS    = 11'b000_0100_0000,
        S_SLOPE = 11'b000_1000_0000,
        S_GAIN  = 11'b001_0000_0000,
        S_SCALE = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_bk_state;

    // Control from the sequencer to each channel lane
    typedef struct packed {
        logic      load;
        t_bk_state state;
    } t_lane_ctl;

endpackage

@@ design/seue_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seue_front
// Input side: accepts stereo frames while the queue has room and tags each
// sample with its magnitude.
// ----------------------------------------------------------------------------
module seue_front (
    input  logic               i_in_valid,
    input  seue_pkg::t_frame_in i_in_data,
    output logic               o_in_stall,
    input  logic               i_full,
    output logic               o_push,
    output seue_pkg::t_work    o_entry
);
    import seue_pkg::*;

    // Magnitude of a two's complement sample; the most negative value maps
    // onto its exact unsigned magnitude
    function automatic logic [SAMPLE_W-1:0] mag_of(input logic signed [SAMPLE_W-1:0] x);
        logic [SAMPLE_W-1:0] m;
        m = x[SAMPLE_W-1] ? (~x + 1'b1) : x;
        return m;
    endfunction

    // Stall only on a full queue
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    // Classify the beat
    always_comb begin
        o_entry.left_x    = i_in_data.left_in;
        o_entry.left_mag  = mag_of(i_in_data.left_in);
        o_entry.right_x   = i_in_data.right_in;
        o_entry.right_mag = mag_of(i_in_data.right_in);
    end

endmodule

@@ design/seue_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seue_queue
// Short FIFO of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module seue_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  seue_pkg::t_work i_data,
    output logic            o_full,
    input  logic            i_pop,
    output seue_pkg::t_work o_data,
    output logic            o_empty
);
    import seue_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_work              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and track fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

@@ design/seue_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seue_lane
// One channel datapath: envelope follower, gain computation with clamp,
// sample scaling and saturation, stepped by the back-end sequencer.
// ----------------------------------------------------------------------------
module seue_lane #(
    parameter int ENV_EXTRA_BITS = seue_pkg::ENV_EXTRA_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  seue_pkg::t_lane_ctl               i_ctl,
    input  seue_pkg::t_cfg                    i_cfg,
    input  logic signed [seue_pkg::SAMPLE_W-1:0] i_x,
    input  logic        [seue_pkg::SAMPLE_W-1:0] i_mag,
    output logic signed [seue_pkg::SAMPLE_W-1:0] o_y
);
    import seue_pkg::*;

    localparam int SW    = SAMPLE_W;
    localparam int F     = SW - 1;
    localparam int E     = ENV_EXTRA_BITS;
    localparam int EW    = SW + E;                  // envelope width
    localparam int PW    = COEF_W + 32;             // coefficient partial product
    localparam int FLW   = LEVEL_W + E;             // floor at envelope scale
    localparam int CMPW  = (EW > FLW) ? EW : FLW;
    localparam int GTW   = (SW > LEVEL_W) ? SW : LEVEL_W;
    localparam int DSW   = SW + 1;                  // envelope minus magnitude, sample scale
    localparam int TMW   = SLOPE_W + DSW;           // slope product
    localparam int TS    = F + 2;                   // slope product shift
    localparam int TW    = TMW - TS + 1;            // gain offset
    localparam int GW    = TW + 2;                  // signed raw gain
    localparam int PRW   = SW + GAIN_W + 1;         // scaled sample
    localparam int QW    = PRW - 14;

    localparam logic signed [GW-1:0] G_UNITY = GW'(UNITY_Q14);
    localparam logic signed [QW-1:0] Q_MAX   = {{(QW-F){1'b0}}, {F{1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN   = {{(QW-F){1'b1}}, {F{1'b0}}};

    logic signed [SW-1:0] r_x;
    logic [SW-1:0]        r_mag;
    logic                 r_up;
    logic [EW-1:0]        r_d;
    logic [EW-1:0]        r_env;
    logic [EW-1:0]        r_acc;
    logic [PW-1:0]        r_plo;
    logic [EW-1:0]        r_step;
    logic                 r_open;
    logic                 r_neg;
    logic [EW-1:0]        r_dm;
    logic [DSW-1:0]       r_ds;
    logic [TMW-1:0]       r_tm;
    logic [GAIN_W-1:0]    r_g;
    logic signed [PRW-1:0] r_p;

    logic [EW-1:0]        w_mext_in;
    logic [EW-1:0]        w_mext;
    logic [COEF_W-1:0]    w_coef;
    logic [63:0]          w_d_pad;
    logic [PW-1:0]        w_prod_hi;
    logic [PW-1:0]        w_prod_lo;
    logic [PW+7:0]        w_hi_sh;
    logic [FLW-1:0]       w_floor_ext;
    logic                 w_open;
    logic                 w_neg;
    logic [DSW-1:0]       w_ds;
    logic [TW-1:0]        w_t;
    logic signed [GW-1:0] w_tg;
    logic signed [GW-1:0] w_g;
    logic signed [GW-1:0] w_limit;
    logic [GAIN_W-1:0]    w_g_clamp;
    logic signed [GAIN_W:0] w_gs;
    logic signed [QW-1:0] w_q;
    logic signed [SW-1:0] w_sat;

    // Magnitudes at envelope scale
    assign w_mext_in = {i_mag, {E{1'b0}}};
    assign w_mext    = {r_mag, {E{1'b0}}};

    // Envelope step: coefficient times distance, in two 32-bit halves
    assign w_coef    = r_up ? i_cfg.attack_coef : i_cfg.release_coef;
    assign w_d_pad   = 64'(r_d);
    assign w_prod_hi = PW'(w_coef) * PW'(w_d_pad[63:32]);
    assign w_prod_lo = PW'(w_coef) * PW'(w_d_pad[31:0]);
    assign w_hi_sh   = {w_prod_hi, 8'b0};

    // Expansion gate on the updated envelope
    assign w_floor_ext = {i_cfg.envelope_floor, {E{1'b0}}};
    assign w_open = (GTW'(r_mag) > GTW'(i_cfg.gate_level)) &&
                    (CMPW'(r_env) > CMPW'(w_floor_ext));
    assign w_neg  = (r_env < w_mext);

    // Distance at sample scale, floored
    assign w_ds = {1'b0, r_dm[EW-1:E]} + DSW'(r_neg && (r_dm[E-1:0] != '0));

    // Gain offset, floored, then clamp to [0, limit]
    assign w_t     = {1'b0, r_tm[TMW-1:TS]} + TW'(r_neg && (r_tm[TS-1:0] != '0));
    assign w_tg    = signed'(GW'(w_t));
    assign w_g     = r_neg ? (G_UNITY - w_tg) : (G_UNITY + w_tg);
    assign w_limit = signed'(GW'(i_cfg.gain_limit));

    always_comb begin
        if (w_g > w_limit) begin
            w_g_clamp = i_cfg.gain_limit;
        end else if (w_g < 0) begin
            w_g_clamp = '0;
        end else begin
            w_g_clamp = w_g[GAIN_W-1:0];
        end
    end

    assign w_gs = signed'({1'b0, r_g});

    // Drop the Q2.14 fraction (arithmetic shift floors) and saturate
    assign w_q = signed'(r_p[PRW-1:14]);

    always_comb begin
        if (w_q > Q_MAX) begin
            w_sat = {1'b0, {F{1'b1}}};
        end else if (w_q < Q_MIN) begin
            w_sat = {1'b1, {F{1'b0}}};
        end else begin
            w_sat = w_q[SW-1:0];
        end
    end

    assign o_y = r_open ? w_sat : r_x;

    // Envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= '0;
        end else if (i_ctl.state == S_ENV) begin
            r_env <= r_up ? (r_env + r_step) : (r_env - r_step);
        end
    end

    // Step the datapath
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.state)
            S_IDLE: begin
                if (i_ctl.load) begin
                    r_x   <= i_x;
                    r_mag <= i_mag;
                    r_up  <= (w_mext_in > r_env);
                    r_d   <= (w_mext_in > r_env) ? (w_mext_in - r_env) : (r_env - w_mext_in);
                end
            end
            S_MHI: begin
                r_acc <= w_hi_sh[EW-1:0];
            end
            S_MLO: begin
                r_plo <= w_prod_lo;
            end
            S_ADD: begin
                r_step <= r_acc + EW'(r_plo >> 24);
            end
            S_ENV: begin
            end
            S_GATE: begin
                r_open <= w_open;
                r_neg  <= w_neg;
                r_dm   <= w_neg ? (w_mext - r_env) : (r_env - w_mext);
            end
            S_DS: begin
                r_ds <= w_ds;
            end
            S_SLOPE: begin
                r_tm <= TMW'(i_cfg.gain_slope) * TMW'(r_ds);
            end
            S_GAIN: begin
                r_g <= w_g_clamp;
            end
            S_SCALE: begin
                r_p <= r_x * w_gs;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/seue_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seue_back
// Execution side: pops classified frames, sequences both channel lanes and
// holds the finished frame in the output register.
// ----------------------------------------------------------------------------
module seue_back #(
    parameter int ENV_EXTRA_BITS = seue_pkg::ENV_EXTRA_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  seue_pkg::t_cfg       i_cfg,
    input  logic                 i_empty,
    input  seue_pkg::t_work      i_entry,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output seue_pkg::t_frame_out o_out_data
);
    import seue_pkg::*;

    t_bk_state  r_state;
    t_bk_state  n_state;
    logic       r_out_valid;
    t_frame_out r_out;

    t_lane_ctl            w_ctl;
    logic signed [SAMPLE_W-1:0] w_left_y;
    logic signed [SAMPLE_W-1:0] w_right_y;
    logic                 w_out_load;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign w_ctl.load  = o_pop;
    assign w_ctl.state = r_state;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Channel lanes run in lockstep
    seue_lane #(
        .ENV_EXTRA_BITS(ENV_EXTRA_BITS)
    ) u_left (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_cfg  (i_cfg),
        .i_x    (i_entry.left_x),
        .i_mag  (i_entry.left_mag),
        .o_y    (w_left_y)
    );

    seue_lane #(
        .ENV_EXTRA_BITS(ENV_EXTRA_BITS)
    ) u_right (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_cfg  (i_cfg),
        .i_x    (i_entry.right_x),
        .i_mag  (i_entry.right_mag),
        .o_y    (w_right_y)
    );

    // Sequence the lane steps
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_empty) n_state = S_MHI;
            S_MHI:   n_state = S_MLO;
            S_MLO:   n_state = S_ADD;
            S_ADD:   n_state = S_ENV;
            S_ENV:   n_state = S_GATE;
            S_GATE:  n_state = S_DS;
            S_DS:    n_state = S_SLOPE;
            S_SLOPE: n_state = S_GAIN;
            S_GAIN:  n_state = S_SCALE;
            S_SCALE: n_state = S_DONE;
            S_DONE:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.left_out  <= w_left_y;
            r_out.right_out <= w_right_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pop_reaches_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> ##10 (r_state == S_DONE))
        else $error("popped frame did not reach the done step");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> $stable(r_out))
        else $error("stalled result overwritten");

    a_pop_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !$past(r_state == S_SCALE))
        else $error("frame popped while a frame was still in the lanes");

endmodule

@@ design/stereo_envelope_upward_expander_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_envelope_upward_expander_unit
// Stereo upward expander: per-channel envelope followers drive a clamped
// gain that lifts samples above the gate level whose envelope sits above the floor.
//
//   channel   direction   handshake                 payload
//   in        sink        i_in_valid / o_in_stall   i_in_data  (t_frame_in)
//   out       source      o_out_valid / i_out_stall o_out_data (t_frame_out)
//   cfg       sink        APB psel/penable/pwrite   paddr, pwdata, prdata
//
// A frame is popped on the idle step and walks the lane steps (two coefficient
// partial products, envelope update, gain, scaling) to the done step, where it
// lands in the output register once that is free; eleven steps with the idle
// step, one frame at a time. Up to two frames wait in the queue.
// Reset is synchronous, active low: envelopes clear to zero, registers load
// their defaults. A stalled output holds its beat while the next frame is
// worked on; the input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module stereo_envelope_upward_expander_unit #(
    parameter int ENV_EXTRA_BITS = seue_pkg::ENV_EXTRA_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  seue_pkg::t_frame_in                i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output seue_pkg::t_frame_out               o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [seue_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [seue_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [seue_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import seue_pkg::*;

    t_cfg       r_cfg;
    logic       w_cfg_wr;
    logic [2:0] w_reg_idx;

    logic   w_push;
    t_work  w_push_entry;
    logic   w_full;
    logic   w_pop;
    t_work  w_head;
    logic   w_empty;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[4:2];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coef    <= RST_ATTACK;
            r_cfg.release_coef   <= RST_RELEASE;
            r_cfg.gate_level     <= RST_GATE;
            r_cfg.envelope_floor <= RST_FLOOR;
            r_cfg.gain_slope     <= RST_SLOPE;
            r_cfg.gain_limit     <= RST_LIMIT;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_ATTACK:  r_cfg.attack_coef    <= pwdata[COEF_W-1:0];
                REG_RELEASE: r_cfg.release_coef   <= pwdata[COEF_W-1:0];
                REG_GATE:    r_cfg.gate_level     <= pwdata[LEVEL_W-1:0];
                REG_FLOOR:   r_cfg.envelope_floor <= pwdata[LEVEL_W-1:0];
                REG_SLOPE:   r_cfg.gain_slope     <= pwdata[SLOPE_W-1:0];
                REG_LIMIT:   r_cfg.gain_limit     <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (w_reg_idx)
            REG_ATTACK:  prdata = CFG_DATA_W'(r_cfg.attack_coef);
            REG_RELEASE: prdata = CFG_DATA_W'(r_cfg.release_coef);
            REG_GATE:    prdata = CFG_DATA_W'(r_cfg.gate_level);
            REG_FLOOR:   prdata = CFG_DATA_W'(r_cfg.envelope_floor);
            REG_SLOPE:   prdata = CFG_DATA_W'(r_cfg.gain_slope);
            REG_LIMIT:   prdata = CFG_DATA_W'(r_cfg.gain_limit);
            default:     prdata = '0;
        endcase
    end

    seue_front u_front (
        .i_in_valid(i_in_valid),
        .i_in_data (i_in_data),
        .o_in_stall(o_in_stall),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_entry   (w_push_entry)
    );

    seue_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_entry),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_data (w_head),
        .o_empty(w_empty)
    );

    seue_back #(
        .ENV_EXTRA_BITS(ENV_EXTRA_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (w_empty),
        .i_entry    (w_head),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo envelope upward expander. A queue-fed
// driver sends stereo frames, a monitor checks each output beat against a
// bit-true predictor of the per-channel envelope and gain math, and the APB
// port is written and read back between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import seue_pkg::*;

    localparam int     ENV_EXTRA     = ENV_EXTRA_DEF;
    localparam int     ENV_W         = SAMPLE_W + ENV_EXTRA;
    localparam int     PROD_W        = COEF_W + ENV_W;
    localparam int     LIFT_SHIFT    = SAMPLE_W + 1;
    localparam int     GAIN_FRAC     = 14;
    localparam longint SAMPLE_MAX    = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN    = -(longint'(1) << (SAMPLE_W - 1));
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_FRAMES  = 192;
    localparam int     SETTLE_CYCLES = 30;
    localparam int     WATCHDOG_CYCLES = 2000;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [ENV_W-1:0]           env;
        logic signed [SAMPLE_W-1:0] y;
    } t_channel_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_frame_in             i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_frame_out            o_out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state and bookkeeping
    t_cfg             gain_cfg;
    logic [ENV_W-1:0] left_env = '0;
    logic [ENV_W-1:0] right_env = '0;
    t_frame_in        pending_frames[$];
    t_frame_out       expected_frames[$];
    t_frame_out       due_frame;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               error_count = 0;
    int               frames_checked = 0;
    int               samples_reshaped = 0;
    int               settings_loaded = 0;
    int               idle_cycles = 0;

    stereo_envelope_upward_expander_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Advance one channel: envelope follower, then gated gain and saturation
    function automatic t_channel_step expand_channel(input logic signed [SAMPLE_W-1:0] x,
                                                     input logic [ENV_W-1:0] env_prev);
        t_channel_step     res;
        logic [SAMPLE_W-1:0] mag;
        logic [ENV_W-1:0]  mag_ext;
        logic [ENV_W-1:0]  env_next;
        logic [ENV_W-1:0]  gap;
        logic [PROD_W-1:0] step;
        logic              below;
        longint unsigned   ds;
        longint unsigned   lift_raw;
        longint            lift;
        longint            gain;
        longint            scaled;
        mag = x[SAMPLE_W-1] ? SAMPLE_W'(-x) : SAMPLE_W'(x);
        mag_ext = ENV_W'(mag) << ENV_EXTRA;
        if (mag_ext > env_prev) begin
            step = PROD_W'(gain_cfg.attack_coef) * PROD_W'(mag_ext - env_prev);
            env_next = env_prev + ENV_W'(step >> COEF_W);
        end else begin
            step = PROD_W'(gain_cfg.release_coef) * PROD_W'(env_prev - mag_ext);
            env_next = env_prev - ENV_W'(step >> COEF_W);
        end
        res.env = env_next;
        res.y = x;
        if (mag > gain_cfg.gate_level &&
            env_next > (ENV_W'(gain_cfg.envelope_floor) << ENV_EXTRA)) begin
            // floor() of a negative distance rounds the magnitude up
            below = env_next < mag_ext;
            gap = below ? mag_ext - env_next : env_next - mag_ext;
            ds = longint'(gap >> ENV_EXTRA);
            if (below && gap[ENV_EXTRA-1:0] != '0)
                ds = ds + 1;
            lift_raw = longint'(gain_cfg.gain_slope) * ds;
            lift = longint'(lift_raw >> LIFT_SHIFT);
            if (below && lift_raw[LIFT_SHIFT-1:0] != '0)
                lift = lift + 1;
            gain = below ? UNITY_Q14 - lift : UNITY_Q14 + lift;
            if (gain > longint'(gain_cfg.gain_limit))
                gain = longint'(gain_cfg.gain_limit);
            if (gain < 0)
                gain = 0;
            scaled = (longint'(x) * gain) >>> GAIN_FRAC;
            if (scaled > SAMPLE_MAX)
                scaled = SAMPLE_MAX;
            if (scaled < SAMPLE_MIN)
                scaled = SAMPLE_MIN;
            res.y = SAMPLE_W'(scaled);
        end
        return res;
    endfunction

    // Run both channels and queue the frame the block must produce
    task automatic predict_frame(input t_frame_in f);
        t_channel_step left_step;
        t_channel_step right_step;
        t_frame_out    o;
        left_step = expand_channel(f.left_in, left_env);
        right_step = expand_channel(f.right_in, right_env);
        left_env = left_step.env;
        right_env = right_step.env;
        o.left_out = left_step.y;
        o.right_out = right_step.y;
        if (o.left_out != f.left_in)
            samples_reshaped++;
        if (o.right_out != f.right_in)
            samples_reshaped++;
        expected_frames.push_back(o);
    endtask

    // Input driver: predict on each accepted beat, then present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_frame(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_frames.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_frames.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Output monitor: compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected output beat left %0d right %0d",
                         $time, o_out_data.left_out, o_out_data.right_out);
                error_count++;
            end else begin
                due_frame = expected_frames.pop_front();
                frames_checked++;
                if (o_out_data.left_out !== due_frame.left_out) begin
                    $display("%0t: left_out expected %0d, got %0d",
                             $time, due_frame.left_out, o_out_data.left_out);
                    error_count++;
                end
                if (o_out_data.right_out !== due_frame.right_out) begin
                    $display("%0t: right_out expected %0d, got %0d",
                             $time, due_frame.right_out, o_out_data.right_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: timeout, no beat for %0d cycles, %0d frames outstanding",
                     $time, idle_cycles, expected_frames.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Register value as the block should report it
    function automatic logic [CFG_DATA_W-1:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_ATTACK:  return CFG_DATA_W'(gain_cfg.attack_coef);
            REG_RELEASE: return CFG_DATA_W'(gain_cfg.release_coef);
            REG_GATE:    return CFG_DATA_W'(gain_cfg.gate_level);
            REG_FLOOR:   return CFG_DATA_W'(gain_cfg.envelope_floor);
            REG_SLOPE:   return CFG_DATA_W'(gain_cfg.gain_slope);
            default:     return CFG_DATA_W'(gain_cfg.gain_limit);
        endcase
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // Keep only the register's width; writes past the map are dropped
        case (idx)
            REG_ATTACK:  gain_cfg.attack_coef = value[COEF_W-1:0];
            REG_RELEASE: gain_cfg.release_coef = value[COEF_W-1:0];
            REG_GATE:    gain_cfg.gate_level = value[LEVEL_W-1:0];
            REG_FLOOR:   gain_cfg.envelope_floor = value[LEVEL_W-1:0];
            REG_SLOPE:   gain_cfg.gain_slope = value[SLOPE_W-1:0];
            REG_LIMIT:   gain_cfg.gain_limit = value[GAIN_W-1:0];
            default:     ;
        endcase
    endtask

    task automatic cfg_readback(input logic [2:0] idx);
        logic [CFG_DATA_W-1:0] got;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== reg_value(idx)) begin
            $display("%0t: register %0d expected %0h, got %0h",
                     $time, idx, reg_value(idx), got);
            error_count++;
        end
    endtask

    task automatic check_all_regs();
        cfg_readback(REG_ATTACK);
        cfg_readback(REG_RELEASE);
        cfg_readback(REG_GATE);
        cfg_readback(REG_FLOOR);
        cfg_readback(REG_SLOPE);
        cfg_readback(REG_LIMIT);
    endtask

    // Write a full setting with junk above each field, then read it back
    task automatic load_config(input t_cfg c);
        cfg_write(REG_ATTACK, ($urandom() << COEF_W) | CFG_DATA_W'(c.attack_coef));
        cfg_write(REG_RELEASE, ($urandom() << COEF_W) | CFG_DATA_W'(c.release_coef));
        cfg_write(REG_GATE, ($urandom() << LEVEL_W) | CFG_DATA_W'(c.gate_level));
        cfg_write(REG_FLOOR, ($urandom() << LEVEL_W) | CFG_DATA_W'(c.envelope_floor));
        cfg_write(REG_SLOPE, ($urandom() << SLOPE_W) | CFG_DATA_W'(c.gain_slope));
        cfg_write(REG_LIMIT, ($urandom() << GAIN_W) | CFG_DATA_W'(c.gain_limit));
        check_all_regs();
        settings_loaded++;
    endtask

    // Random setting, biased toward fast attack and low thresholds
    function automatic t_cfg random_setting();
        t_cfg c;
        c.attack_coef = ($urandom_range(0, 3) == 0) ? COEF_W'($urandom()) :
                        COEF_W'($urandom_range(24'h100000, 24'hFFFFFF));
        c.release_coef = COEF_W'($urandom()) >> $urandom_range(0, 16);
        c.gate_level = LEVEL_W'($urandom_range(0, 1 << 23) >> $urandom_range(4, 23));
        c.envelope_floor = LEVEL_W'($urandom_range(0, 1 << 23) >> $urandom_range(2, 23));
        c.gain_slope = SLOPE_W'($urandom());
        c.gain_limit = ($urandom_range(0, 9) == 0) ?
                       GAIN_W'($urandom_range(0, UNITY_Q14 - 1)) :
                       GAIN_W'($urandom_range(UNITY_Q14, 32767));
        return c;
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 86; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default:       begin send_idle_pct = 9;  recv_stall_pct = 9;  end
        endcase
    endtask

    task automatic queue_frame(input longint l, input longint r);
        t_frame_in f;
        f.left_in = SAMPLE_W'(l);
        f.right_in = SAMPLE_W'(r);
        pending_frames.push_back(f);
    endtask

    // Sample of the given magnitude with random sign, kept in range
    function automatic longint signed_sample(input longint mag);
        if ($urandom_range(0, 1) == 1)
            return -mag;
        return (mag > SAMPLE_MAX) ? SAMPLE_MAX : mag;
    endfunction

    function automatic longint boundary_sample();
        case ($urandom_range(0, 4))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return 0;
            3:       return 1;
            default: return -1;
        endcase
    endfunction

    // Mostly loud-then-quiet bursts so envelopes build up and expansion kicks in
    task automatic queue_random_frames(input int count);
        int     made;
        int     len;
        int     k;
        longint level;
        longint left_mag;
        longint right_mag;
        made = 0;
        while (made < count) begin
            case ($urandom_range(0, 9))
                0: begin
                    queue_frame($urandom(), $urandom());
                    made++;
                end
                1: begin
                    queue_frame(boundary_sample(), boundary_sample());
                    made++;
                end
                default: begin
                    level = longint'($urandom_range(1, 1 << 23)) >> $urandom_range(0, 18);
                    len = $urandom_range(4, 32);
                    for (k = 0; k < len; k++) begin
                        if (k < len / 2) begin
                            left_mag = $urandom_range(level / 2, level);
                            right_mag = $urandom_range(level / 2, level);
                        end else begin
                            left_mag = $urandom_range(0, level >> $urandom_range(1, 8));
                            right_mag = $urandom_range(0, level >> $urandom_range(0, 8));
                        end
                        queue_frame(signed_sample(left_mag), signed_sample(right_mag));
                    end
                    made += len;
                end
            endcase
        end
    endtask

    // Wait until every queued frame has gone through and been checked
    task automatic drain();
        while (pending_frames.size() != 0 || i_in_valid || expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int ph;
        gain_cfg = '{attack_coef: RST_ATTACK, release_coef: RST_RELEASE,
                     gate_level: RST_GATE, envelope_floor: RST_FLOOR,
                     gain_slope: RST_SLOPE, gain_limit: RST_LIMIT};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_all_regs();

        // Reset defaults: sample extremes, most negative sample included
        set_idling(IDLE_NONE);
        queue_frame(0, 0);
        queue_frame(SAMPLE_MAX, SAMPLE_MIN);
        queue_frame(SAMPLE_MIN, SAMPLE_MAX);
        queue_frame(1, -1);
        queue_frame(-1, 1);
        queue_frame(24'h400000, -24'h400000);
        drain();

        // Maximum setting: envelope jumps up, quiet samples get full gain,
        // a loud sample after quiet ones sees a gain just under unity
        load_config('{attack_coef: 24'hFFFFFF, release_coef: 24'hFFFFFF, gate_level: 24'd0,
                      envelope_floor: 24'd0, gain_slope: 16'hFFFF, gain_limit: 15'h7FFF});
        queue_frame(SAMPLE_MAX, SAMPLE_MIN);
        queue_frame(SAMPLE_MIN, SAMPLE_MAX);
        queue_frame(1, -1);
        queue_frame(24'h600000, -24'h600000);
        queue_frame(-24'h000010, 24'h000010);
        queue_frame(SAMPLE_MIN, SAMPLE_MIN);
        queue_frame(0, 0);
        queue_frame(SAMPLE_MAX, SAMPLE_MAX);
        drain();

        // Gain limit under unity: expanded samples are cut instead
        load_config('{attack_coef: 24'hFFFFFF, release_coef: 24'd0, gate_level: 24'd0,
                      envelope_floor: 24'd0, gain_slope: 16'd0, gain_limit: 15'd0});
        queue_frame(SAMPLE_MAX, SAMPLE_MIN);
        queue_frame(24'h123456, -24'h123456);
        drain();

        // Minimum setting: gate and floor at full scale, nothing is expanded
        load_config('{attack_coef: 24'd0, release_coef: 24'd0, gate_level: 24'h800000,
                      envelope_floor: 24'h800000, gain_slope: 16'd0, gain_limit: 15'd16384});
        cfg_write(REG_UNUSED, $urandom());
        check_all_regs();
        queue_frame(SAMPLE_MIN, SAMPLE_MAX);
        queue_frame(-2, 2);
        drain();

        // Random settings, each under one of the four idling patterns in turn
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_config(random_setting());
            set_idling(t_idle_mode'(ph % 4));
            queue_random_frames(PHASE_FRAMES);
            drain();
        end

        $display("Checked %0d stereo frames under %0d register settings;",
                 frames_checked, settings_loaded);
        $display("%0d samples were changed by the gain stage.", samples_reshaped);
        if (error_count == 0 && expected_frames.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
